[hw/rtl/bnh_pkg.sv]
// ----------------------------------------------------------------------------
// bnh_pkg
// Shared types and constants for the bounded navigation history unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bnh_pkg;

  // Default sizes handed to the top level
  localparam int DEPTH_DEF         = 16;
  localparam int POSITION_BITS_DEF = 32;

  // Limit register
  localparam int             CFG_W         = 5;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  // Operation codes carried by an item
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_PREV  = 2'd1,
    KIND_NEXT  = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_SCAN,
    ST_PICK,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/bnh_ram.sv]
// ----------------------------------------------------------------------------
// bnh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bounded_navigation_history_unit.sv]
// ----------------------------------------------------------------------------
// bounded_navigation_history_unit
// Back/forward history of position marks with a cursor, kept in a circular
// RAM and walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        input      in_valid / in_ready      kind, position, position_valid
//  out       output     out_valid / out_ready    moved, current_position,
//                                                current_valid, has_previous,
//                                                has_following, entry_count,
//                                                cursor_index
//  cfg       input      cfg_write_en (no wait)   cfg_write_data (max_entries)
//
// An accepted item passes through the walk (ST_SCAN), ST_PICK and ST_OUT to the
// result register; an add first passes ST_TRIM to drop entries over the limit.
// The walk reads one RAM entry per cycle through the shared slot adder and
// the single RAM read port.
// One item is in work at a time; the next item is taken while a result waits.
// A stalled result holds in the output register and holds the sequencer.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_navigation_history_unit
  import bnh_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [POSITION_BITS-1:0]         position,
  input  logic                             position_valid,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             moved,
  output logic [POSITION_BITS-1:0]         current_position,
  output logic                             current_valid,
  output logic                             has_previous,
  output logic                             has_following,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count,
  output logic [$clog2(DEPTH+1)-1:0]       cursor_index,
  input  logic                             cfg_write_en,
  input  logic [CFG_W-1:0]                 cfg_write_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CW   = $clog2(DEPTH + 2);
  localparam int SW   = CW + 1;
  localparam int LIMW = (CW > CFG_W) ? CW : CFG_W;
  localparam int RW   = POSITION_BITS + 1;

  // Control state
  state_t           state;
  state_t           state_next;
  kind_t            kind_q;
  logic [CW-1:0]    count;
  logic [CW-1:0]    cursor;
  logic [AW-1:0]    oldest;
  logic [CFG_W-1:0] max_entries;

  // Scan state
  logic [CW-1:0]    scan_idx;
  logic [CW-1:0]    rd_idx;
  logic             rd_pend;
  logic             before1;
  logic             before2;
  logic             at_cur;
  logic             after1;
  logic             after2;
  logic [CW-1:0]    last_before;
  logic [CW-1:0]    first_after;
  logic             moved_q;
  logic             hp_q;
  logic             hf_q;

  // Datapath nets
  logic             accept;
  logic             ram_we;
  logic [RW-1:0]    ram_q;
  logic [CW-1:0]    slot_idx;
  logic [SW-1:0]    slot_sum;
  logic [AW-1:0]    slot;
  logic [CFG_W-1:0] lim_src;
  logic [LIMW-1:0]  lim_ext;
  logic [CW-1:0]    lim;
  logic             over;
  logic [CW-1:0]    drop;
  logic [CW-1:0]    cursor_trim;
  logic             scan_more;
  logic             scan_done;
  logic [CW-1:0]    cursor_fin;
  logic             moved_fin;
  logic             hp_fin;
  logic             hf_fin;
  logic             out_free;
  logic             cur_in;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign scan_more = scan_idx < count;
  assign scan_done = !scan_more && !rd_pend;
  assign cur_in    = cursor < count;

  // Effective limit: the register, or the data being written, clamped at DEPTH
  always_comb begin
    lim_src = cfg_write_en ? cfg_write_data : max_entries;
    lim_ext = LIMW'(lim_src);
    if (lim_ext > LIMW'(DEPTH)) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(lim_ext);
    end
  end

  // Trim amounts
  assign over        = count > lim;
  assign drop        = count - lim;
  assign cursor_trim = (cursor > drop) ? (cursor - drop) : '0;

  // Shared slot adder: history index to RAM slot
  always_comb begin
    slot_sum = SW'(oldest) + SW'(slot_idx);
    if (slot_sum >= SW'(DEPTH)) begin
      slot = AW'(slot_sum - SW'(DEPTH));
    end else begin
      slot = AW'(slot_sum);
    end
  end

  // Final cursor and neighbor flags after the walk
  always_comb begin
    cursor_fin = cursor;
    moved_fin  = 1'b0;
    hp_fin     = before1;
    hf_fin     = after1;
    if (kind_q == KIND_PREV && before1) begin
      cursor_fin = last_before;
      moved_fin  = 1'b1;
      hp_fin     = before2;
      hf_fin     = at_cur || after1;
    end else if (kind_q == KIND_NEXT && after1) begin
      cursor_fin = first_after;
      moved_fin  = 1'b1;
      hp_fin     = before1 || at_cur;
      hf_fin     = after2;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind_t'(kind) == KIND_ADD) ? ST_TRIM : ST_SCAN;
        end
      end
      ST_TRIM: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, RAM write, slot adder select
  always_comb begin
    in_ready = (state == ST_IDLE);
    ram_we   = 1'b0;
    slot_idx = cursor;
    if (cfg_write_en) begin
      slot_idx = drop;
    end else begin
      case (state)
        ST_IDLE: begin
          slot_idx = cursor;
          ram_we   = accept && (kind_t'(kind) == KIND_ADD);
        end
        ST_TRIM: slot_idx = drop;
        ST_SCAN: slot_idx = scan_idx;
        ST_PICK: slot_idx = cursor_fin;
        ST_OUT:  slot_idx = cursor;
        default: slot_idx = cursor;
      endcase
    end
  end

  // Mark store: payload with its valid bit on top
  bnh_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({position_valid, position}),
    .raddr (slot),
    .rdata (ram_q)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // History registers, limit register and trim
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      cursor      <= '0;
      oldest      <= '0;
      max_entries <= MAX_ENTRIES_RST;
    end else if (cfg_write_en) begin
      max_entries <= cfg_write_data;
      if (over) begin
        oldest <= slot;
        count  <= lim;
        cursor <= cursor_trim;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind_t'(kind) == KIND_ADD) begin
              count  <= cursor + CW'(1);
              cursor <= cursor + CW'(1);
            end else if (kind_t'(kind) == KIND_FLUSH) begin
              count  <= '0;
              cursor <= '0;
              oldest <= '0;
            end
          end
        end
        ST_TRIM: begin
          if (over) begin
            oldest <= slot;
            count  <= lim;
            cursor <= cursor_trim;
          end
        end
        ST_PICK: cursor <= cursor_fin;
        default: ;
      endcase
    end
  end

  // Walk the history one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (state == ST_SCAN) begin
      rd_pend <= scan_more;
    end else begin
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind_t'(kind);
      scan_idx <= '0;
      before1  <= 1'b0;
      before2  <= 1'b0;
      at_cur   <= 1'b0;
      after1   <= 1'b0;
      after2   <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (scan_more) begin
        rd_idx   <= scan_idx;
        scan_idx <= scan_idx + CW'(1);
      end
      if (rd_pend && ram_q[RW-1]) begin
        if (rd_idx < cursor) begin
          before2     <= before1;
          before1     <= 1'b1;
          last_before <= rd_idx;
        end else if (rd_idx == cursor) begin
          at_cur <= 1'b1;
        end else begin
          after2 <= after1;
          after1 <= 1'b1;
          if (!after1) begin
            first_after <= rd_idx;
          end
        end
      end
    end else if (state == ST_PICK) begin
      moved_q <= moved_fin;
      hp_q    <= hp_fin;
      hf_q    <= hf_fin;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      moved            <= moved_q;
      current_position <= cur_in ? ram_q[POSITION_BITS-1:0] : '0;
      current_valid    <= cur_in && ram_q[RW-1];
      has_previous     <= hp_q;
      has_following    <= hf_q;
      entry_count      <= count[CNTW-1:0];
      cursor_index     <= cursor[CNTW-1:0];
    end
  end

endmodule

[hw/rtl/bnh_checker.sv]
// ----------------------------------------------------------------------------
// bnh_checker
// Port-level checks for the bounded navigation history unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bnh_checker
  import bnh_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       moved,
  input logic [POSITION_BITS-1:0]   current_position,
  input logic                       current_valid,
  input logic                       has_previous,
  input logic [$clog2(DEPTH+1)-1:0] entry_count,
  input logic [$clog2(DEPTH+1)-1:0] cursor_index
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_position)
      && $stable(cursor_index) && $stable(entry_count))
    else $error("result changed while stalled");

  // Cursor never passes the end of the history
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_index <= entry_count)
    else $error("cursor beyond entry count");

  // A move always lands on a valid entry
  a_moved_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved |-> current_valid)
    else $error("cursor moved onto an invalid entry");

  // Nothing lies before the oldest entry
  a_prev_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_previous |-> cursor_index != '0)
    else $error("previous entry reported at index zero");

endmodule

bind bounded_navigation_history_unit bnh_checker #(
  .DEPTH         (DEPTH),
  .POSITION_BITS (POSITION_BITS)
) u_bnh_checker (.*);
